/* hdl/wfss_pkg.sv */
// ----------------------------------------------------------------------------
// wfss_pkg
// types and constants shared by the fair slice scheduler modules
// ----------------------------------------------------------------------------
package wfss_pkg;

   localparam int ID_MAX_W   = 8;   // ids of up to 256 task slots
   localparam int TIME_MAX_W = 32;  // 16 whole bits plus up to 16 fraction bits
   localparam int DIVISOR_W  = 10;  // weight sum plus one weight, less the bias

   localparam logic [3:0] FINISH_BIAS = 4'd4;

   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_RAN      = 3'd2;
   localparam logic [2:0] ST_FINISHED = 3'd3;
   localparam logic [2:0] ST_ALL_DONE = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic CSR_QUANTUM   = 1'b0;
   localparam logic CSR_CPU_COUNT = 1'b1;

   // one table entry, also the candidate that travels along the cell row
   typedef struct packed {
      logic                  valid;
      logic [ID_MAX_W-1:0]   id;
      logic [31:0]           vruntime;
      logic [31:0]           order;
      logic [15:0]           runtime;
      logic [3:0]            weight;
      logic [TIME_MAX_W-1:0] elapsed;
   } entry_type;

   // write of one entry into the cell whose slot matches id
   typedef struct packed {
      logic      we;
      entry_type data;
   } cell_cmd_type;

endpackage

/* hdl/wfss_cell.sv */
// ----------------------------------------------------------------------------
// wfss_cell
// one task slot; keeps the better of its own entry and the neighbor's candidate
// ----------------------------------------------------------------------------
module wfss_cell import wfss_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int TIME_W     = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    best_in,
   output entry_type    best_out
);

   logic                    valid_ff;
   logic [31:0]             vruntime_ff;
   logic [31:0]             order_ff;
   logic [15:0]             runtime_ff;
   logic [3:0]              weight_ff;
   logic [TIME_W-1:0]       elapsed_ff;
   entry_type               own;
   entry_type               best_ff;
   entry_type               best_in_w;
   logic                    own_wins;
   logic                    hit;

   assign hit = cmd.we && (cmd.data.id == ID_MAX_W'(CELL_INDEX));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (hit) begin
         valid_ff <= cmd.data.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         vruntime_ff <= cmd.data.vruntime;
         order_ff    <= cmd.data.order;
         runtime_ff  <= cmd.data.runtime;
         weight_ff   <= cmd.data.weight;
         elapsed_ff  <= cmd.data.elapsed[TIME_W-1:0];
      end
   end

   always_comb begin
      own          = best_in;
      own.valid    = valid_ff;
      own.id       = ID_MAX_W'(CELL_INDEX);
      own.vruntime = vruntime_ff;
      own.order    = order_ff;
      own.runtime  = runtime_ff;
      own.weight   = weight_ff;
      own.elapsed  = TIME_MAX_W'(elapsed_ff);
      own_wins = valid_ff && (!best_in.valid || (vruntime_ff < best_in.vruntime) ||
                 ((vruntime_ff == best_in.vruntime) && (order_ff < best_in.order)));
      best_in_w = own_wins ? own : best_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in_w;
      end
   end

   assign best_out = best_ff;

endmodule

/* hdl/wfss_div.sv */
// ----------------------------------------------------------------------------
// wfss_div
// restoring divider for the slice, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wfss_div import wfss_pkg::*; #(
   parameter int TIME_W = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [TIME_W-1:0]    quotient
);

   localparam int CNT_W = $clog2(TIME_W + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [TIME_W-1:0]    quo_ff;
   logic [DIVISOR_W:0]   rem_ff;
   logic [DIVISOR_W-1:0] dsr_ff;
   logic [DIVISOR_W:0]   trial_in;
   logic [DIVISOR_W:0]   diff_in;

   always_comb begin
      trial_in = {rem_ff[DIVISOR_W-1:0], quo_ff[TIME_W-1]};
      diff_in  = trial_in - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(TIME_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff_in[DIVISOR_W]) begin
            rem_ff <= diff_in;
            quo_ff <= {quo_ff[TIME_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial_in;
            quo_ff <= {quo_ff[TIME_W-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/weighted_fair_slice_scheduler.sv */
// ----------------------------------------------------------------------------
// weighted_fair_slice_scheduler
// least-virtual-runtime task scheduler with weighted time slices
// ----------------------------------------------------------------------------
// Requests enter on req_ (opcode 0 adds a task, 1 runs one scheduling step)
// and every request gives one response on rsp_. Both sides use valid/stall.
// The csr_ port writes quantum (index 0) and cpu_count (index 1); the user
// must write it only while idle, which the block does not enforce. Tasks
// sit in a row of MAX_TASKS cells; a step lets the best candidate travel
// down the row, one cell per cycle, then S_CALC and S_APPLY charge the
// task. A slice recompute runs a bit-serial divider; an add can start one
// when the work sum exceeds the quantum, a step when a task finishes. One
// request is processed at a time; req_stall is high while busy. A response
// waiting under rsp_stall holds its fields, and the next request is still
// taken, but its response waits for the slot to free. Reset empties the
// table, zeroes clock and sums and loads quantum 100 and cpu_count 1.
// ----------------------------------------------------------------------------
module weighted_fair_slice_scheduler import wfss_pkg::*; #(
   parameter int MAX_TASKS = 16,
   parameter int MAX_CPUS  = 8,
   parameter int FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic [15:0]        req_task_runtime,
   input  logic [3:0]         req_task_weight,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [3:0]         rsp_task_id,
   output logic [2:0]         rsp_cpu_index,
   output logic [31:0]        rsp_clock_value,
   output logic signed [31:0] rsp_switch_overhead,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int TIME_W = 16 + FRAC_BITS;
   localparam int NID_W  = $clog2(MAX_TASKS + 1);
   localparam int SCAN_W = $clog2(MAX_TASKS + 2);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_CALC  = 3'd2;
   localparam logic [2:0] S_APPLY = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]         state_ff;
   logic [SCAN_W-1:0]  scan_ff;
   logic [15:0]        quantum_ff;
   logic [3:0]         cpu_count_ff;
   logic [31:0]        clock_ff;
   logic [TIME_W-1:0]  slice_ff;
   logic [23:0]        work_sum_ff;
   logic [7:0]         weight_sum_ff;
   logic [NID_W-1:0]   live_ff;
   logic [2:0]         next_cpu_ff;
   logic [NID_W-1:0]   next_id_ff;
   logic [31:0]        stamp_ff;
   entry_type          pick_ff;
   logic [TIME_W-1:0]  adv_ff;

   logic [2:0]         res_status_ff;
   logic [3:0]         res_id_ff;
   logic [2:0]         res_cpu_ff;
   logic [31:0]        res_ovh_ff;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [3:0]         rsp_id_ff;
   logic [2:0]         rsp_cpu_ff;
   logic [31:0]        rsp_clock_ff;
   logic [31:0]        rsp_ovh_ff;

   cell_cmd_type       cmd;
   entry_type          chain [MAX_TASKS+1];
   entry_type          head;

   logic               req_take;
   logic               rsp_load;
   logic [24:0]        work_add;
   logic [23:0]        work_sum_in;
   logic [8:0]         weight_add;
   logic [7:0]         weight_sum_in;
   logic [TIME_W-1:0]  full;
   logic [TIME_W-1:0]  elapsed_cur;
   logic [TIME_W-1:0]  rem;
   logic [TIME_W-1:0]  adv_in;
   logic [TIME_W-1:0]  elapsed_in;
   logic               finished;
   logic [31:0]        clock_in;
   logic [3:0]         eff_cpus;
   logic [3:0]         cpu_sel;
   logic [3:0]         cpu_next;
   logic [10:0]        fin_sum;
   logic               div_start;
   logic [DIVISOR_W-1:0] div_divisor;
   logic               div_done;
   logic [TIME_W-1:0]  div_quotient;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // response slot is loaded when it is empty or being taken this cycle
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // ---------------- cell row ----------------
   always_comb begin
      head       = '0;
      head.valid = 1'b0;
   end

   assign chain[0] = head;

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      wfss_cell #(
         .CELL_INDEX (g),
         .TIME_W     (TIME_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .best_in  (chain[g]),
         .best_out (chain[g+1])
      );
   end

   // ---------------- arithmetic ----------------
   always_comb begin
      work_add      = {1'b0, work_sum_ff} + 25'(req_task_runtime);
      work_sum_in   = work_add[24] ? 24'hFFFFFF : work_add[23:0];
      weight_add    = {1'b0, weight_sum_ff} + 9'(req_task_weight);
      weight_sum_in = weight_add[8] ? 8'hFF : weight_add[7:0];

      full        = {pick_ff.runtime, FRAC_BITS'(0)};
      elapsed_cur = pick_ff.elapsed[TIME_W-1:0];
      rem         = (elapsed_cur >= full) ? '0 : full - elapsed_cur;
      if ({8'd0, quantum_ff} >= work_sum_ff) begin
         adv_in = TIME_W'(1) << FRAC_BITS;
      end else begin
         adv_in = (rem > slice_ff) ? slice_ff : rem;
      end

      elapsed_in = elapsed_cur + adv_ff;
      finished   = (elapsed_in >= full);
      clock_in   = clock_ff + 32'(adv_ff);

      if (cpu_count_ff == 4'd0) begin
         eff_cpus = 4'd1;
      end else if (cpu_count_ff > 4'(MAX_CPUS)) begin
         eff_cpus = 4'(MAX_CPUS);
      end else begin
         eff_cpus = cpu_count_ff;
      end
      cpu_sel  = ({1'b0, next_cpu_ff} >= eff_cpus) ? 4'd0 : {1'b0, next_cpu_ff};
      cpu_next = (cpu_sel + 4'd1 >= eff_cpus) ? 4'd0 : cpu_sel + 4'd1;

      fin_sum = 11'(weight_sum_ff) + 11'(pick_ff.weight);
   end

   // ---------------- table writes and divider start ----------------
   always_comb begin
      cmd         = '0;
      div_start   = 1'b0;
      div_divisor = '0;
      if (state_ff == S_IDLE && req_take && req_opcode == OP_ADD &&
          next_id_ff < NID_W'(MAX_TASKS)) begin
         cmd.we            = 1'b1;
         cmd.data.valid    = 1'b1;
         cmd.data.id       = ID_MAX_W'(next_id_ff);
         cmd.data.vruntime = 32'(req_task_weight);
         cmd.data.order    = stamp_ff;
         cmd.data.runtime  = req_task_runtime;
         cmd.data.weight   = req_task_weight;
         cmd.data.elapsed  = '0;
         if ({8'd0, quantum_ff} < work_sum_in && weight_sum_in != 8'd0) begin
            div_start   = 1'b1;
            div_divisor = DIVISOR_W'(weight_sum_in);
         end
      end else if (state_ff == S_APPLY) begin
         cmd.we            = 1'b1;
         cmd.data          = pick_ff;
         cmd.data.valid    = !finished;
         cmd.data.vruntime = pick_ff.vruntime + 32'(pick_ff.weight);
         cmd.data.order    = stamp_ff;
         cmd.data.elapsed  = TIME_MAX_W'(elapsed_in);
         // finish divisor is weight sum plus this weight, less the bias
         if (finished && fin_sum > 11'(FINISH_BIAS)) begin
            div_start   = 1'b1;
            div_divisor = DIVISOR_W'(fin_sum - 11'(FINISH_BIAS));
         end
      end
   end

   wfss_div #(
      .TIME_W (TIME_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({quantum_ff, FRAC_BITS'(0)}),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= 16'd100;
         cpu_count_ff <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_QUANTUM:   quantum_ff   <= csr_wdata;
            CSR_CPU_COUNT: cpu_count_ff <= csr_wdata[3:0];
            default:       quantum_ff   <= quantum_ff;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_ff       <= '0;
         clock_ff      <= '0;
         slice_ff      <= '0;
         work_sum_ff   <= '0;
         weight_sum_ff <= '0;
         live_ff       <= '0;
         next_cpu_ff   <= '0;
         next_id_ff    <= '0;
         stamp_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  if (req_opcode == OP_STEP) begin
                     scan_ff  <= SCAN_W'(MAX_TASKS + 1);
                     state_ff <= S_SCAN;
                  end else if (next_id_ff >= NID_W'(MAX_TASKS)) begin
                     state_ff <= S_DONE;
                  end else begin
                     next_id_ff    <= next_id_ff + 1'b1;
                     stamp_ff      <= stamp_ff + 32'd1;
                     live_ff       <= live_ff + 1'b1;
                     work_sum_ff   <= work_sum_in;
                     weight_sum_ff <= weight_sum_in;
                     state_ff      <= div_start ? S_DIV : S_DONE;
                  end
               end
            end
            S_SCAN: begin
               // candidate moves through the cell registers one by one to reach the row's end
               scan_ff <= scan_ff - 1'b1;
               if (scan_ff == SCAN_W'(1)) begin
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               if (!pick_ff.valid) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               clock_ff    <= clock_in;
               stamp_ff    <= stamp_ff + 32'd1;
               next_cpu_ff <= cpu_next[2:0];
               if (finished && live_ff != '0) begin
                  live_ff <= live_ff - 1'b1;
               end
               state_ff <= div_start ? S_DIV : S_DONE;
            end
            S_DIV: begin
               if (div_done) begin
                  slice_ff <= div_quotient;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN) begin
         pick_ff <= chain[MAX_TASKS];
      end
      if (state_ff == S_CALC) begin
         adv_ff <= adv_in;
      end
      case (state_ff)
         S_IDLE: begin
            res_cpu_ff <= 3'd0;
            res_ovh_ff <= 32'd0;
            if (next_id_ff >= NID_W'(MAX_TASKS)) begin
               res_status_ff <= ST_FULL;
               res_id_ff     <= 4'd0;
            end else begin
               res_status_ff <= ST_ADDED;
               res_id_ff     <= 4'(next_id_ff);
            end
         end
         S_CALC: begin
            res_status_ff <= ST_EMPTY;
            res_id_ff     <= 4'd0;
            res_cpu_ff    <= 3'd0;
            res_ovh_ff    <= 32'd0;
         end
         S_APPLY: begin
            res_id_ff  <= 4'(pick_ff.id);
            res_cpu_ff <= cpu_sel[2:0];
            res_ovh_ff <= 32'd0;
            if (!finished) begin
               res_status_ff <= ST_RAN;
            end else if (live_ff <= NID_W'(1)) begin
               res_status_ff <= ST_ALL_DONE;
               res_ovh_ff    <= clock_in - (32'(work_sum_ff) << FRAC_BITS);
            end else begin
               res_status_ff <= ST_FINISHED;
            end
         end
         default: res_id_ff <= res_id_ff;
      endcase
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_cpu_ff    <= res_cpu_ff;
         rsp_clock_ff  <= clock_ff;
         rsp_ovh_ff    <= res_ovh_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_task_id         = rsp_id_ff;
   assign rsp_cpu_index       = rsp_cpu_ff;
   assign rsp_clock_value     = rsp_clock_ff;
   assign rsp_switch_overhead = $signed(rsp_ovh_ff);

endmodule

/* tb/tb_weighted_fair_slice_scheduler.sv */
// ----------------------------------------------------------------------------
// tb_weighted_fair_slice_scheduler
// self-checking testbench for the weighted fair slice scheduler
// ----------------------------------------------------------------------------
// Requests are driven on req_ under random sender gaps and receiver stalls.
// An in-testbench model of the task table, fair clock and slice predicts
// every response. Responses are checked field by field, in order.
// Directed tests cover the empty table, a zero slice, extreme runtimes and
// quantum and cpu count corners; random phases follow, then a full table.
// ----------------------------------------------------------------------------
module tb_weighted_fair_slice_scheduler import wfss_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NTASK = 16;
   localparam int NCPU  = 8;
   localparam int FRAC  = 8;
   localparam longint unsigned TMASK = (64'd1 << (16 + FRAC)) - 1;
   localparam int SETTLE = 80;

   typedef struct {
      logic [2:0]         status;
      logic [3:0]         id;
      logic [2:0]         cpu;
      logic [31:0]        clk_val;
      logic signed [31:0] ovh;
   } sched_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_opcode = OP_ADD;
   logic [15:0]        req_task_runtime = '0;
   logic [3:0]         req_task_weight = 4'd1;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic [3:0]         rsp_task_id;
   logic [2:0]         rsp_cpu_index;
   logic [31:0]        rsp_clock_value;
   logic signed [31:0] rsp_switch_overhead;
   logic               csr_we = 1'b0;
   logic               csr_index = CSR_QUANTUM;
   logic [15:0]        csr_wdata = '0;

   weighted_fair_slice_scheduler DUT (.*);

   always #5 clock = ~clock;

   // scheduler model state
   logic [15:0]     m_quantum = 16'd100;
   logic [3:0]      m_cpus = 4'd1;
   bit              t_valid [NTASK];
   logic [15:0]     t_runtime [NTASK];
   logic [3:0]      t_weight [NTASK];
   longint unsigned t_elapsed [NTASK];
   logic [31:0]     t_vrun [NTASK];
   logic [31:0]     t_order [NTASK];
   logic [31:0]     fair_clk = '0;
   longint unsigned slice_len = 0;
   int unsigned     work_total = 0;
   int unsigned     weight_total = 0;
   int unsigned     live_tasks = 0;
   int unsigned     cpu_next = 0;
   int unsigned     id_next = 0;
   logic [31:0]     stamp = '0;

   sched_rsp_type pending_rsp [$];
   int         errors = 0;
   int         requests = 0;
   int         status_seen [6];
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         hold_cycles = 0;

   function automatic void update_slice(longint divisor);
      longint unsigned v;
      if (divisor > 0) begin
         v = (longint'(m_quantum) << FRAC) / divisor;
         slice_len = (v > TMASK) ? TMASK : v;
      end
   endfunction

   function automatic sched_rsp_type schedule_request(logic op, logic [15:0] rt, logic [3:0] wt);
      sched_rsp_type r;
      int pick;
      int unsigned eff, cpu, id;
      longint unsigned full, rem, adv;
      r = '{ST_ADDED, 4'd0, 3'd0, 32'd0, 32'sd0};
      if (op == OP_ADD) begin
         if (id_next >= NTASK) begin
            r.status = ST_FULL;
         end else begin
            id = id_next;
            id_next++;
            t_valid[id] = 1;
            t_runtime[id] = rt;
            t_weight[id] = wt;
            t_elapsed[id] = 0;
            t_vrun[id] = 32'(wt);
            t_order[id] = stamp;
            stamp++;
            live_tasks++;
            work_total = (work_total + rt > 24'hFFFFFF) ? 24'hFFFFFF : work_total + rt;
            weight_total = (weight_total + wt > 255) ? 255 : weight_total + wt;
            if (work_total > m_quantum) update_slice(weight_total);
            r.id = 4'(id);
         end
         r.clk_val = fair_clk;
         return r;
      end
      pick = -1;
      for (int i = 0; i < NTASK; i++)
         if (t_valid[i] && (pick < 0 || t_vrun[i] < t_vrun[pick] ||
             (t_vrun[i] == t_vrun[pick] && t_order[i] < t_order[pick])))
            pick = i;
      if (pick < 0) begin
         r.status = ST_EMPTY;
         r.clk_val = fair_clk;
         return r;
      end
      full = longint'(t_runtime[pick]) << FRAC;
      rem = (t_elapsed[pick] >= full) ? 0 : full - t_elapsed[pick];
      if (m_quantum >= work_total) adv = 64'd1 << FRAC;
      else adv = (rem > slice_len) ? slice_len : rem;
      fair_clk = fair_clk + adv[31:0];
      t_elapsed[pick] = (t_elapsed[pick] + adv) & TMASK;
      t_vrun[pick] = t_vrun[pick] + 32'(t_weight[pick]);
      t_order[pick] = stamp;
      stamp++;
      eff = (m_cpus == 0) ? 1 : ((m_cpus > NCPU) ? NCPU : m_cpus);
      cpu = (cpu_next >= eff) ? 0 : cpu_next;
      cpu_next = (cpu + 1 >= eff) ? 0 : cpu + 1;
      r.id = 4'(pick);
      r.cpu = 3'(cpu);
      r.clk_val = fair_clk;
      if (t_elapsed[pick] >= full) begin
         t_valid[pick] = 0;
         if (live_tasks > 0) live_tasks--;
         update_slice(longint'(weight_total) + t_weight[pick] - 4);
         if (live_tasks == 0) begin
            r.status = ST_ALL_DONE;
            r.ovh = fair_clk - (work_total << FRAC);
         end else begin
            r.status = ST_FINISHED;
         end
      end else begin
         r.status = ST_RAN;
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      errors++;
      $display("%0t: response %s mismatch: got %0d expected %0d", $realtime, field, got, want);
   endtask

   // response checker
   always @(posedge clock) begin
      sched_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected", rsp_status, -1);
         end else begin
            e = pending_rsp.pop_front();
            status_seen[e.status]++;
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_task_id !== e.id) report_mismatch("task_id", rsp_task_id, e.id);
            if (rsp_cpu_index !== e.cpu) report_mismatch("cpu_index", rsp_cpu_index, e.cpu);
            if (rsp_clock_value !== e.clk_val)
               report_mismatch("clock_value", rsp_clock_value, e.clk_val);
            if (rsp_switch_overhead !== e.ovh)
               report_mismatch("switch_overhead", rsp_switch_overhead, e.ovh);
         end
      end
   end

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // leaves req_valid high after acceptance so back-to-back requests without an idle gap do not toggle it
   task automatic send_request(logic op, logic [15:0] rt, logic [3:0] wt);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_task_runtime <= rt;
      req_task_weight <= wt;
      do @(posedge clock); while (req_stall);
      pending_rsp = {pending_rsp, schedule_request(op, rt, wt)};
      requests++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_QUANTUM) m_quantum = value;
      else m_cpus = value[3:0];
   endtask

   task automatic step_until_idle(int limit);
      for (int n = 0; n < limit && live_tasks > 0; n++) send_request(OP_STEP, '0, 4'd1);
   endtask

   task automatic test_empty_and_zero_slice();
      send_request(OP_STEP, 16'hFFFF, 4'd15);
      // work within quantum leaves the slice at zero; a smaller quantum then stalls progress
      send_request(OP_ADD, 16'd50, 4'd3);
      write_csr(CSR_QUANTUM, 16'd1);
      send_request(OP_STEP, '0, 4'd1);
      send_request(OP_STEP, '0, 4'd1);
      send_request(OP_ADD, 16'd0, 4'd15);
      repeat (4) send_request(OP_STEP, '0, 4'd1);
   endtask

   task automatic test_extremes();
      write_csr(CSR_QUANTUM, 16'hFFFF);
      write_csr(CSR_CPU_COUNT, 16'd8);
      send_request(OP_ADD, 16'hFFFF, 4'd1);
      step_until_idle(30);
      send_request(OP_STEP, '0, 4'd1);
   endtask

   task automatic random_phase(int count, int id_budget, int idle, int stall, bit hold);
      logic [15:0] rt;
      idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < count; n++) begin
         if (hold && n == count / 2) hold_cycles = 400;
         rt = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
         if (id_next < id_budget && $urandom_range(0, 9) == 0)
            send_request(OP_ADD, rt, 4'($urandom_range(1, 15)));
         else if ($urandom_range(0, 49) == 0)
            send_request(OP_ADD, rt, 4'($urandom_range(1, 15)));  // may hit a full table
         else
            send_request(OP_STEP, rt, 4'($urandom_range(1, 15)));
      end
      drain();
   endtask

   task automatic test_random();
      write_csr(CSR_QUANTUM, 16'd1);
      write_csr(CSR_CPU_COUNT, 16'd0);
      random_phase(420, 8, 0, 0, 0);
      write_csr(CSR_QUANTUM, 16'($urandom_range(2, 2000)));
      write_csr(CSR_CPU_COUNT, 16'd15);
      random_phase(420, 11, 82, 0, 1);
      write_csr(CSR_QUANTUM, 16'($urandom_range(1, 65535)));
      write_csr(CSR_CPU_COUNT, 16'($urandom_range(1, 8)));
      random_phase(400, 14, 0, 82, 0);
      write_csr(CSR_QUANTUM, 16'd100);
      write_csr(CSR_CPU_COUNT, 16'd3);
      random_phase(400, 15, 14, 14, 0);
   endtask

   task automatic test_table_full();
      idle_pct = 0;
      stall_pct = 30;
      while (id_next < NTASK) send_request(OP_ADD, 16'd3, 4'($urandom_range(1, 15)));
      send_request(OP_ADD, 16'd7, 4'd2);
      send_request(OP_ADD, 16'hA5A5, 4'd9);
      step_until_idle(20);
      send_request(OP_STEP, '0, 4'd1);
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_zero_slice();
      test_extremes();
      test_random();
      test_table_full();
      if (pending_rsp.size() != 0) report_mismatch("missing responses", 0, pending_rsp.size());
      $display("covered %0d requests; added/full/ran/finished/all-done/empty = %0d/%0d/%0d/%0d/%0d/%0d",
               requests, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5]);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #30ms;
      $display("timeout waiting for scheduler");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
